>>> rtl/core/pio_pkg.sv
// Shared constants and types for the point-in-obstacle test block.
package pio_pkg;

  localparam int MAX_OBSTACLES_DEF = 16;
  localparam int COORD_BITS_DEF    = 20;
  localparam int RADIUS_BITS       = 19;
  localparam int COUNT_BITS        = 5;

  localparam logic REQ_WRITE    = 1'b0;
  localparam logic REQ_QUERY    = 1'b1;
  localparam logic SHAPE_SPHERE = 1'b1;

  typedef struct packed {
    logic done;
    logic hit;
  } eval_sts_t;

  typedef struct packed {
    logic load;
    logic neg;
    logic clr;
  } mac_ctl_t;

endpackage

>>> rtl/core/point_in_obstacle_test.sv
// Point-in-obstacle test: obstacle table ring, query control and result register.
// Write item: stored in the table slot given by slot_i, no result.
// Query item: one lap of MAX_OBSTACLES ring steps plus, for each checked slot up to the first
// hit, a run of serial multiplies on Wm-bit operands: 4 multiplies for a sphere, up to 17
// for a cylinder (Wm = 43 at 20-bit coordinates); the shared serial multiplier sets the rate.
// Reset clears control state and the obstacle count; table contents stay undefined until written.
module point_in_obstacle_test import pio_pkg::*; #(
  parameter int MaxObstacles = MAX_OBSTACLES_DEF,
  parameter int CoordBits    = COORD_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   req_type_i,
  input  logic [3:0]             slot_i,
  input  logic signed [CoordBits-1:0] pos_x_i,
  input  logic signed [CoordBits-1:0] pos_y_i,
  input  logic signed [CoordBits-1:0] pos_z_i,
  input  logic signed [CoordBits-1:0] end_x_i,
  input  logic signed [CoordBits-1:0] end_y_i,
  input  logic signed [CoordBits-1:0] end_z_i,
  input  logic [RADIUS_BITS-1:0] obstacle_radius_i,
  input  logic                   shape_kind_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   inside_res_o,
  input  logic                   cfg_we_i,
  input  logic [COUNT_BITS-1:0]  cfg_wdata_i
);

  localparam int Ew = 6 * CoordBits + RADIUS_BITS + 1;
  localparam int Nw = $clog2(MaxObstacles + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_WAIT, ST_DONE} state_e;

  state_e                  state_q;
  logic [COUNT_BITS-1:0]   count_q;
  logic [Nw-1:0]           k_q, n_q, n_d;
  logic                    hit_q;
  logic                    out_valid_q, inside_q;
  logic [3*CoordBits-1:0]  point_q;
  logic [Ew-1:0]           wdata;
  logic [Ew-1:0]           entry [MaxObstacles];
  logic                    in_acc, wr_acc, shift, start;
  eval_sts_t               sts;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign wr_acc     = in_acc && (req_type_i == REQ_WRITE);
  assign shift      = (state_q == ST_RUN) && (k_q != Nw'(MaxObstacles));
  assign start      = shift && !hit_q && (k_q < n_q);
  assign wdata      = {shape_kind_i, obstacle_radius_i, end_z_i, end_y_i, end_x_i,
                       pos_z_i, pos_y_i, pos_x_i};

  always_comb begin
    if (int'(count_q) > MaxObstacles) begin
      n_d = Nw'(MaxObstacles);
    end else begin
      n_d = Nw'(count_q);
    end
  end

  for (genvar i = 0; i < MaxObstacles; i++) begin : g_cell
    pio_cell #(
      .EntryW(Ew)
    ) u_cell (
      .clk_i  (clk_i),
      .we_i   (wr_acc && (int'(slot_i) == i)),
      .wdata_i(wdata),
      .shift_i(shift),
      .next_i (entry[(i + 1) % MaxObstacles]),
      .entry_o(entry[i])
    );
  end

  pio_eval #(
    .CoordBits(CoordBits)
  ) u_eval (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .point_i(point_q),
    .entry_i(entry[0]),
    .sts_o  (sts)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      k_q         <= '0;
      n_q         <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
      inside_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc && (req_type_i == REQ_QUERY)) begin
            k_q     <= '0;
            n_q     <= n_d;
            hit_q   <= 1'b0;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (k_q == Nw'(MaxObstacles)) begin
            state_q <= ST_DONE;
          end else begin
            k_q <= k_q + 1'b1;
            if (start) begin
              state_q <= ST_WAIT;
            end
          end
        end
        ST_WAIT: begin
          if (sts.done) begin
            hit_q   <= sts.hit;
            state_q <= ST_RUN;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            inside_q    <= hit_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      point_q <= {pos_z_i, pos_y_i, pos_x_i};
    end
  end

  assign out_valid_o  = out_valid_q;
  assign inside_res_o = inside_q;

endmodule

>>> rtl/core/pio_cell.sv
// One obstacle cell of the rotating table ring.
module pio_cell #(
  parameter int EntryW = 140
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [EntryW-1:0] wdata_i,
  input  logic              shift_i,
  input  logic [EntryW-1:0] next_i,
  output logic [EntryW-1:0] entry_o
);

  logic [EntryW-1:0] entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    if (we_i) begin
      entry_d = wdata_i;
    end else if (shift_i) begin
      entry_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

>>> rtl/core/pio_mac.sv
// Serial signed multiply-accumulate unit, eight multiplier bits per cycle.
module pio_mac import pio_pkg::*; #(
  parameter int Wm   = 43,
  parameter int Wacc = 88
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mac_ctl_t               ctl_i,
  input  logic signed [Wm-1:0]   a_i,
  input  logic signed [Wm-1:0]   b_i,
  output logic                   done_o,
  output logic signed [Wacc-1:0] acc_o
);

  localparam int Steps = (Wm + 7) / 8;
  localparam int CntW  = $clog2(Steps);

  logic [Wm-1:0]          a_mag, b_mag;
  logic [Wacc-1:0]        a_sh_q;
  logic [Wm-1:0]          b_q;
  logic                   neg_q;
  logic [CntW-1:0]        cnt_q;
  logic                   busy_q, done_q;
  logic signed [Wacc-1:0] acc_q, acc_d;
  logic [Wacc+7:0]        pp;
  logic [Wacc-1:0]        ppt;

  always_comb begin
    a_mag = a_i[Wm-1] ? -a_i : a_i;
    b_mag = b_i[Wm-1] ? -b_i : b_i;
    pp    = a_sh_q * b_q[7:0];
    ppt   = pp[Wacc-1:0];
    acc_d = neg_q ? (acc_q - $signed(ppt)) : (acc_q + $signed(ppt));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.load) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(Steps - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      a_sh_q <= Wacc'(a_mag);
      b_q    <= b_mag;
      neg_q  <= a_i[Wm-1] ^ b_i[Wm-1] ^ ctl_i.neg;
      if (ctl_i.clr) begin
        acc_q <= '0;
      end
    end else if (busy_q) begin
      acc_q  <= acc_d;
      a_sh_q <= a_sh_q << 8;
      b_q    <= b_q >> 8;
    end
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;

endmodule

>>> rtl/core/pio_eval.sv
// Sequencer that tests one point against one sphere or finite cylinder.
module pio_eval import pio_pkg::*; #(
  parameter int CoordBits = COORD_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [3*CoordBits-1:0]             point_i,
  input  logic [6*CoordBits+RADIUS_BITS:0]   entry_i,
  output eval_sts_t                          sts_o
);

  localparam int Cb   = CoordBits;
  localparam int D    = Cb + 1;
  localparam int Wm   = (2 * D + 1 > 2 * RADIUS_BITS + 1) ? 2 * D + 1 : 2 * RADIUS_BITS + 1;
  localparam int Wacc = 2 * Wm + 2;
  localparam int Ew   = 6 * Cb + RADIUS_BITS + 1;

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT} state_e;
  typedef enum logic [4:0] {
    OP_SP0, OP_SP1, OP_SP2, OP_SPR,
    OP_AA0, OP_AA1, OP_AA2,
    OP_DT0, OP_DT1, OP_DT2,
    OP_CX0, OP_CX1, OP_CY0, OP_CY1, OP_CZ0, OP_CZ1,
    OP_RR, OP_LS0, OP_LS1, OP_LS2, OP_RHS
  } op_e;

  state_e state_q;
  op_e    op_q;
  eval_sts_t sts_q;

  logic signed [D-1:0]    ap_q [3];
  logic signed [D-1:0]    ab_q [3];
  logic signed [D-1:0]    ap_d [3];
  logic signed [D-1:0]    ab_d [3];
  logic [RADIUS_BITS-1:0] r_q;
  logic signed [Wm-1:0]   ab2_q, cx_q, cy_q, cz_q, r2_q;
  logic signed [Wacc-1:0] lhs_q;

  mac_ctl_t               mac_ctl;
  logic signed [Wm-1:0]   opa, opb, r_ext;
  logic                   mac_done;
  logic signed [Wacc-1:0] acc;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ap_d[i] = D'($signed(point_i[i*Cb +: Cb])) - D'($signed(entry_i[i*Cb +: Cb]));
      ab_d[i] = D'($signed(entry_i[(i+3)*Cb +: Cb])) - D'($signed(entry_i[i*Cb +: Cb]));
    end
  end

  assign r_ext = Wm'(r_q);

  always_comb begin
    opa = Wm'(ap_q[0]);
    opb = Wm'(ap_q[0]);
    mac_ctl.neg = 1'b0;
    mac_ctl.clr = 1'b0;
    mac_ctl.load = (state_q == ST_ISSUE);
    case (op_q)
      OP_SP0: begin opa = Wm'(ap_q[0]); opb = Wm'(ap_q[0]); mac_ctl.clr = 1'b1; end
      OP_SP1: begin opa = Wm'(ap_q[1]); opb = Wm'(ap_q[1]); end
      OP_SP2: begin opa = Wm'(ap_q[2]); opb = Wm'(ap_q[2]); end
      OP_SPR: begin opa = r_ext; opb = r_ext; mac_ctl.clr = 1'b1; end
      OP_AA0: begin opa = Wm'(ab_q[0]); opb = Wm'(ab_q[0]); mac_ctl.clr = 1'b1; end
      OP_AA1: begin opa = Wm'(ab_q[1]); opb = Wm'(ab_q[1]); end
      OP_AA2: begin opa = Wm'(ab_q[2]); opb = Wm'(ab_q[2]); end
      OP_DT0: begin opa = Wm'(ap_q[0]); opb = Wm'(ab_q[0]); mac_ctl.clr = 1'b1; end
      OP_DT1: begin opa = Wm'(ap_q[1]); opb = Wm'(ab_q[1]); end
      OP_DT2: begin opa = Wm'(ap_q[2]); opb = Wm'(ab_q[2]); end
      OP_CX0: begin opa = Wm'(ap_q[1]); opb = Wm'(ab_q[2]); mac_ctl.clr = 1'b1; end
      OP_CX1: begin opa = Wm'(ap_q[2]); opb = Wm'(ab_q[1]); mac_ctl.neg = 1'b1; end
      OP_CY0: begin opa = Wm'(ap_q[2]); opb = Wm'(ab_q[0]); mac_ctl.clr = 1'b1; end
      OP_CY1: begin opa = Wm'(ap_q[0]); opb = Wm'(ab_q[2]); mac_ctl.neg = 1'b1; end
      OP_CZ0: begin opa = Wm'(ap_q[0]); opb = Wm'(ab_q[1]); mac_ctl.clr = 1'b1; end
      OP_CZ1: begin opa = Wm'(ap_q[1]); opb = Wm'(ab_q[0]); mac_ctl.neg = 1'b1; end
      OP_RR:  begin opa = r_ext; opb = r_ext; mac_ctl.clr = 1'b1; end
      OP_LS0: begin opa = cx_q; opb = cx_q; mac_ctl.clr = 1'b1; end
      OP_LS1: begin opa = cy_q; opb = cy_q; end
      OP_LS2: begin opa = cz_q; opb = cz_q; end
      OP_RHS: begin opa = r2_q; opb = ab2_q; mac_ctl.clr = 1'b1; end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  pio_mac #(
    .Wm  (Wm),
    .Wacc(Wacc)
  ) u_mac (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (mac_ctl),
    .a_i   (opa),
    .b_i   (opb),
    .done_o(mac_done),
    .acc_o (acc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_SP0;
      sts_q   <= '0;
    end else begin
      sts_q.done <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            op_q    <= (entry_i[Ew-1] == SHAPE_SPHERE) ? OP_SP0 : OP_AA0;
            state_q <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          state_q <= ST_WAIT;
        end
        ST_WAIT: begin
          if (mac_done) begin
            state_q <= ST_ISSUE;
            op_q    <= op_e'(op_q + 5'd1);
            case (op_q)
              OP_SPR, OP_RHS: begin
                sts_q.done <= 1'b1;
                sts_q.hit  <= (lhs_q <= acc);
                state_q    <= ST_IDLE;
              end
              OP_AA2: begin
                if (acc == '0) begin
                  sts_q.done <= 1'b1;
                  sts_q.hit  <= 1'b0;
                  state_q    <= ST_IDLE;
                end
              end
              OP_DT2: begin
                if (acc[Wacc-1] || (acc > Wacc'(ab2_q))) begin
                  sts_q.done <= 1'b1;
                  sts_q.hit  <= 1'b0;
                  state_q    <= ST_IDLE;
                end
              end
              OP_RR: begin
                op_q <= OP_LS0;
              end
              default: begin
              end
            endcase
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      ap_q <= ap_d;
      ab_q <= ab_d;
      r_q  <= entry_i[6*Cb +: RADIUS_BITS];
    end
    if (state_q == ST_WAIT && mac_done) begin
      case (op_q)
        OP_SP2, OP_LS2: lhs_q <= acc;
        OP_AA2: ab2_q <= acc[Wm-1:0];
        OP_CX1: cx_q  <= acc[Wm-1:0];
        OP_CY1: cy_q  <= acc[Wm-1:0];
        OP_CZ1: cz_q  <= acc[Wm-1:0];
        OP_RR:  r2_q  <= acc[Wm-1:0];
        default: begin
        end
      endcase
    end
  end

  assign sts_o = sts_q;

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the point-in-obstacle test block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pio_pkg::*;

  localparam int NSLOTS = MAX_OBSTACLES_DEF;
  localparam int CW = COORD_BITS_DEF;
  localparam longint CMAX = (64'sd1 <<< (CW - 1)) - 1;
  localparam longint CMIN = -(64'sd1 <<< (CW - 1));
  localparam int TIMEOUT_CYCLES = 30_000_000;

  typedef logic signed [127:0] wide_t;
  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    logic req;
    logic [3:0] slot;
    coord_t px, py, pz, ex, ey, ez;
    logic [RADIUS_BITS-1:0] rad;
    logic kind;
  } req_item_t;

  class inside_scoreboard;
    longint first_end[NSLOTS][3];
    longint second_end[NSLOTS][3];
    longint radius[NSLOTS];
    logic kind[NSLOTS];
    int count;
    bit inside_q[$];
    int errors;

    function void set_count(int v);
      count = v;
    endfunction

    function bit hits(int k, longint p[3]);
      longint ap[3], ab[3];
      longint r2, d2, ab2, dot, cx, cy, cz;
      wide_t lhs, rhs;
      for (int i = 0; i < 3; i++) begin
        ap[i] = p[i] - first_end[k][i];
        ab[i] = second_end[k][i] - first_end[k][i];
      end
      r2 = radius[k] * radius[k];
      if (kind[k] == SHAPE_SPHERE) begin
        d2 = ap[0] * ap[0] + ap[1] * ap[1] + ap[2] * ap[2];
        return d2 <= r2;
      end
      ab2 = ab[0] * ab[0] + ab[1] * ab[1] + ab[2] * ab[2];
      dot = ap[0] * ab[0] + ap[1] * ab[1] + ap[2] * ab[2];
      if (ab2 == 0 || dot < 0 || dot > ab2) return 0;
      cx = ap[1] * ab[2] - ap[2] * ab[1];
      cy = ap[2] * ab[0] - ap[0] * ab[2];
      cz = ap[0] * ab[1] - ap[1] * ab[0];
      lhs = wide_t'(cx) * wide_t'(cx) + wide_t'(cy) * wide_t'(cy) + wide_t'(cz) * wide_t'(cz);
      rhs = wide_t'(r2) * wide_t'(ab2);
      return lhs <= rhs;
    endfunction

    function void note_input(req_item_t it);
      longint p[3];
      int n;
      bit hit;
      p[0] = it.px;
      p[1] = it.py;
      p[2] = it.pz;
      if (it.req == REQ_WRITE) begin
        for (int i = 0; i < 3; i++) first_end[it.slot][i] = p[i];
        second_end[it.slot][0] = it.ex;
        second_end[it.slot][1] = it.ey;
        second_end[it.slot][2] = it.ez;
        radius[it.slot] = it.rad;
        kind[it.slot] = it.kind;
        return;
      end
      n = (count > NSLOTS) ? NSLOTS : count;
      hit = 0;
      for (int k = 0; k < n && !hit; k++) hit = hits(k, p);
      inside_q = {inside_q, hit};
    endfunction

    function void check_result(logic got);
      if (inside_q.size() == 0) begin
        $error("inside_res: no result expected, got %0d", got);
        errors++;
        return;
      end
      if (got !== inside_q[0]) begin
        $error("inside_res: expected %0d, got %0d", inside_q[0], got);
        errors++;
      end
      void'(inside_q.pop_front());
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic in_ready_o;
  logic req_type_i = 0;
  logic [3:0] slot_i = 0;
  coord_t pos_x_i = 0, pos_y_i = 0, pos_z_i = 0, end_x_i = 0, end_y_i = 0, end_z_i = 0;
  logic [RADIUS_BITS-1:0] obstacle_radius_i = 0;
  logic shape_kind_i = 0;
  logic out_valid_o;
  logic out_ready_i = 0;
  logic inside_res_o;
  logic cfg_we_i = 0;
  logic [COUNT_BITS-1:0] cfg_wdata_i = 0;

  inside_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  longint cycles = 0;

  point_in_obstacle_test dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .req_type_i, .slot_i,
    .pos_x_i, .pos_y_i, .pos_z_i, .end_x_i, .end_y_i, .end_z_i,
    .obstacle_radius_i, .shape_kind_i, .out_valid_o, .out_ready_i, .inside_res_o,
    .cfg_we_i, .cfg_wdata_i
  );

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > TIMEOUT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    req_item_t it;
    if (rst_ni && in_valid_i && in_ready_o) begin
      it.req = req_type_i; it.slot = slot_i;
      it.px = pos_x_i; it.py = pos_y_i; it.pz = pos_z_i;
      it.ex = end_x_i; it.ey = end_y_i; it.ez = end_z_i;
      it.rad = obstacle_radius_i; it.kind = shape_kind_i;
      sb.note_input(it);
    end
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(inside_res_o);
  end

  always @(posedge clk_i) begin
    if (rst_ni) out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_item(req_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    req_type_i <= it.req; slot_i <= it.slot;
    pos_x_i <= it.px; pos_y_i <= it.py; pos_z_i <= it.pz;
    end_x_i <= it.ex; end_y_i <= it.ey; end_z_i <= it.ez;
    obstacle_radius_i <= it.rad; shape_kind_i <= it.kind;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic write_count(int v);
    in_valid_i <= 0;
    @(posedge clk_i);
    while (sb.inside_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_wdata_i <= COUNT_BITS'(v);
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.set_count(v);
  endtask

  function automatic coord_t clamp(longint v);
    if (v > CMAX) return coord_t'(CMAX);
    if (v < CMIN) return coord_t'(CMIN);
    return coord_t'(v);
  endfunction

  function automatic coord_t rnd_coord();
    if ($urandom_range(9) == 0) return coord_t'($urandom);
    return coord_t'(longint'($urandom_range(4000)) - 2000);
  endfunction

  function automatic req_item_t obstacle(int s, longint a[3], longint b[3], int r, logic k);
    req_item_t it;
    it.req = REQ_WRITE; it.slot = s;
    it.px = clamp(a[0]); it.py = clamp(a[1]); it.pz = clamp(a[2]);
    it.ex = clamp(b[0]); it.ey = clamp(b[1]); it.ez = clamp(b[2]);
    it.rad = r; it.kind = k;
    return it;
  endfunction

  function automatic req_item_t point(longint x, longint y, longint z);
    req_item_t it;
    it = '{default: 0};
    it.req = REQ_QUERY;
    it.slot = $urandom; it.ex = $urandom; it.ey = $urandom; it.ez = $urandom;
    it.rad = $urandom; it.kind = $urandom;
    it.px = clamp(x); it.py = clamp(y); it.pz = clamp(z);
    return it;
  endfunction

  function automatic req_item_t rnd_write();
    longint a[3], b[3];
    int r;
    for (int i = 0; i < 3; i++) begin
      a[i] = rnd_coord();
      b[i] = ($urandom_range(9) == 0) ? a[i] : longint'(rnd_coord());
    end
    r = ($urandom_range(7) == 0) ? $urandom_range(2 ** RADIUS_BITS - 1) : $urandom_range(600);
    return obstacle($urandom_range(NSLOTS - 1), a, b, r, $urandom);
  endfunction

  function automatic req_item_t rnd_query(int n);
    int k;
    longint t, q[3];
    if (n == 0 || $urandom_range(9) < 3)
      return point(rnd_coord(), rnd_coord(), rnd_coord());
    k = $urandom_range(((n > NSLOTS) ? NSLOTS : n) - 1);
    t = longint'($urandom_range(10)) - 1;
    for (int i = 0; i < 3; i++)
      q[i] = sb.first_end[k][i] + ((sb.second_end[k][i] - sb.first_end[k][i]) * t) / 8
             + longint'($urandom_range(2 * sb.radius[k] % 4001)) - (sb.radius[k] % 4001);
    return point(q[0], q[1], q[2]);
  endfunction

  initial begin
    longint a[3], b[3];
    int counts[7] = '{16, 0, 31, 1, 17, 8, 5};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // write slots 0 to 5, then ten writes to random slots, before the first query
    a = '{CMIN, CMIN, CMIN}; b = '{CMAX, CMAX, CMAX};
    send_item(obstacle(0, a, b, 0, 1'b0));
    send_item(obstacle(1, a, a, 2 ** RADIUS_BITS - 1, 1'b0));
    send_item(obstacle(2, b, b, 2 ** RADIUS_BITS - 1, SHAPE_SPHERE));
    a = '{0, 0, 0}; b = '{800, 0, 0};
    send_item(obstacle(3, a, b, 80, 1'b0));
    send_item(obstacle(4, a, a, 40, SHAPE_SPHERE));
    send_item(obstacle(5, a, a, 0, SHAPE_SPHERE));
    for (int s = 6; s < NSLOTS; s++) send_item(rnd_write());
    write_count(NSLOTS);
    send_item(point(CMIN, CMIN, CMIN));
    send_item(point(CMAX, CMAX, CMAX));
    send_item(point(400, 80, 0));
    send_item(point(400, 81, 0));
    send_item(point(-1, 0, 0));
    send_item(point(801, 0, 0));
    send_item(point(0, 0, 40));
    send_item(point(0, 0, 0));
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 57 : 0;
      recv_idle_pct = (ph == 0) ? 57 : (ph == 1) ? 35 : 0;
      for (int c = 0; c < 7; c++) begin
        write_count((c == 6) ? $urandom_range(2 ** COUNT_BITS - 1) : counts[(c + ph) % 7]);
        for (int i = 0; i < 95; i++) begin
          if ($urandom_range(9) < 3) send_item(rnd_write());
          else send_item(rnd_query(sb.count));
        end
      end
    end
    in_valid_i <= 0;
    @(posedge clk_i);
    while (sb.inside_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
